// File: design/u2f_pkg.sv
// Shared types, constants and the leading-one encoder for the uint32-to-float32 converter.
package u2f_pkg;

    localparam int unsigned INT_W  = 32;
    localparam int unsigned LEAD_W = 5;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned SIG_W  = FRAC_W + 1;

    localparam logic [EXP_W-1:0]  EXP_BIAS = 8'd127;
    localparam logic [LEAD_W-1:0] LEAD_MAX = 5'd31;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic [LEAD_W-1:0] lead;
    } t_stage_ctl;

    function automatic logic [LEAD_W-1:0] find_lead(input logic [INT_W-1:0] value);
        logic [LEAD_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < INT_W; i++) begin
            if (value[i]) begin
                pos = LEAD_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: design/u2f_lead.sv
// Stage two: leading-one position and zero detect of the registered operand.
module u2f_lead
    import u2f_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [INT_W-1:0] i_value,
    output t_stage_ctl       o_ctl,
    output logic [INT_W-1:0] o_value
);

    logic             r_valid;
    logic             r_zero;
    logic [LEAD_W-1:0] r_lead;
    logic [INT_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero  <= (i_value == '0);
        r_lead  <= find_lead(i_value);
        r_value <= i_value;
    end

    assign o_ctl   = '{valid: r_valid, zero: r_zero, lead: r_lead};
    assign o_value = r_value;

endmodule

// File: design/u2f_norm.sv
// Stage three: left shift that puts the leading one at the top bit.
module u2f_norm
    import u2f_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage_ctl       i_ctl,
    input  logic [INT_W-1:0] i_value,
    output t_stage_ctl       o_ctl,
    output logic [INT_W-1:0] o_norm
);

    logic             r_valid;
    logic             r_zero;
    logic [LEAD_W-1:0] r_lead;
    logic [INT_W-1:0] r_norm;
    logic [LEAD_W-1:0] shift_amt;

    assign shift_amt = LEAD_MAX - i_ctl.lead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= i_ctl.zero;
        r_lead <= i_ctl.lead;
        r_norm <= i_value << shift_amt;
    end

    assign o_ctl  = '{valid: r_valid, zero: r_zero, lead: r_lead};
    assign o_norm = r_norm;

endmodule

// File: design/u2f_round.sv
// Stage four: round to nearest even, exponent build and result register.
module u2f_round
    import u2f_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage_ctl       i_ctl,
    input  logic [INT_W-1:0] i_norm,
    output logic             o_valid,
    output logic [INT_W-1:0] o_bits
);

    logic             r_valid;
    logic [INT_W-1:0] r_bits;
    logic [INT_W-1:0] n_bits;
    logic             guard_bit;
    logic             round_bit;
    logic             sticky;
    logic [SIG_W:0]   kept;
    logic [EXP_W-1:0] exp_base;

    assign guard_bit = i_norm[INT_W-SIG_W];
    assign round_bit = i_norm[INT_W-SIG_W-1];
    assign sticky    = |i_norm[INT_W-SIG_W-2:0];
    assign kept      = {1'b0, i_norm[INT_W-1:INT_W-SIG_W]}
                     + (SIG_W+1)'(round_bit & (guard_bit | sticky));
    assign exp_base  = EXP_W'(i_ctl.lead) + EXP_BIAS;

    always_comb begin
        if (i_ctl.zero) begin
            n_bits = '0;
        end else if (kept[SIG_W]) begin
            n_bits = {1'b0, exp_base + EXP_W'(1), {FRAC_W{1'b0}}};
        end else begin
            n_bits = {1'b0, exp_base, kept[FRAC_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;

endmodule

// File: design/uint32_to_float32_convert_unit.sv
// Unsigned 32-bit integer to IEEE-754 single-precision converter, round to nearest even.
// A four-stage pipeline: operand register, leading-one encoder, normalizing shifter, and
// rounding incrementer with exponent build. One transaction is taken every clock cycle. Its
// result is on o_float_bits with o_valid for one cycle, once it has passed the operand,
// leading-one, normalizing and rounding registers in turn. o_busy stays low, as no stage ever
// holds. Results show for one cycle and cannot be stalled.
module uint32_to_float32_convert_unit
    import u2f_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [INT_W-1:0] i_int_value,
    output logic             o_busy,
    output logic             o_valid,
    output logic [INT_W-1:0] o_float_bits
);

    logic             r_in_valid;
    logic [INT_W-1:0] r_in_value;
    t_stage_ctl       lead_ctl;
    logic [INT_W-1:0] lead_value;
    t_stage_ctl       norm_ctl;
    logic [INT_W-1:0] norm_value;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start & ~o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_value <= i_int_value;
    end

    u2f_lead u_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_value (r_in_value),
        .o_ctl   (lead_ctl),
        .o_value (lead_value)
    );

    u2f_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lead_ctl),
        .i_value (lead_value),
        .o_ctl   (norm_ctl),
        .o_norm  (norm_value)
    );

    u2f_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (norm_ctl),
        .i_norm  (norm_value),
        .o_valid (o_valid),
        .o_bits  (o_float_bits)
    );

endmodule

// File: design/u2f_checker.sv
// Port-level checker for the converter and its bind to the top level.
module u2f_checker
    import u2f_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic [INT_W-1:0] i_int_value,
    input logic             o_busy,
    input logic             o_valid,
    input logic [INT_W-1:0] o_float_bits
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid)
        else $error("result strobe missing four cycles after start");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##4 !o_valid)
        else $error("result strobe without a transaction");

    a_zero_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_int_value == '0) |-> ##4 (o_float_bits == '0))
        else $error("zero input did not give positive zero");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_float_bits != '0) |->
            (!o_float_bits[INT_W-1] && o_float_bits[30:23] >= 8'd127
             && o_float_bits[30:23] <= 8'd159))
        else $error("result sign or exponent out of range");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised");

endmodule

bind uint32_to_float32_convert_unit u2f_checker u_u2f_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .i_int_value  (i_int_value),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_float_bits (o_float_bits)
);
